[hw/rtl/assert_macros.svh]
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Checks that a condition is followed by a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/c3bs_pkg.sv]
// Package with constants, types and helpers of the 3x3 blur and Sobel unit.
package c3bs_pkg;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
  localparam int HEIGHT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int INROW_W    = $clog2(MAX_HEIGHT + 2);
  localparam int CFG_DATA_W = 13;
  localparam int PIX_W      = 24;
  localparam int SQ_W       = 21;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;
  localparam logic MODE_BLUR  = 1'b0;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_CALC  = 7'b0000100,
    S_SQ    = 7'b0001000,
    S_START = 7'b0010000,
    S_ROOT  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  function automatic logic [7:0] chan(input logic [PIX_W-1:0] px, input logic [1:0] c);
    logic [7:0] v;
    case (c)
      2'd0:    v = px[23:16];
      2'd1:    v = px[15:8];
      default: v = px[7:0];
    endcase
    return v;
  endfunction
endpackage

[hw/rtl/c3bs_if.sv]
// Stream interfaces for the pixel input and the filtered pixel output.
interface c3bs_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source (output valid, kind, red_in, green_in, blue_in, input ready);
  modport sink (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface c3bs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       last_of_frame;
  modport source (output valid, red_out, green_out, blue_out, last_of_frame, input ready);
  modport sink (input valid, red_out, green_out, blue_out, last_of_frame, output ready);
endinterface

[hw/rtl/c3bs_isqrt.sv]
// Bit-serial integer square root with saturation at 255, two bits of input per cycle.
module c3bs_isqrt import c3bs_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [SQ_W-1:0] value,
  output logic [7:0]      root_out,
  output logic            busy
);
  logic [15:0] v;
  logic [9:0]  rem;
  logic [9:0]  rem_next;
  logic [7:0]  root;
  logic [7:0]  root_next;
  logic [2:0]  cnt;
  logic        sat;
  logic [11:0] rem_sh;
  logic [11:0] trial;

  always_comb begin
    rem_sh = {rem, v[15:14]};
    trial  = {2'b00, root, 2'b01};
    if (rem_sh >= trial) begin
      rem_next  = 10'(rem_sh - trial);
      root_next = {root[6:0], 1'b1};
    end else begin
      rem_next  = rem_sh[9:0];
      root_next = {root[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      v    <= value[15:0];
      sat  <= |value[SQ_W-1:16];
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      root <= root_next;
      v    <= {v[13:0], 2'b00};
      cnt  <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

  assign root_out = sat ? 8'hFF : root;
endmodule

[hw/rtl/conv3x3_blur_sobel_unit.sv]
// Top level of the streaming 3x3 Gaussian blur and Sobel magnitude filter.
// Pixels enter in raster order, one transaction at a time; each result belongs to the
// position frame_width+1 transactions earlier, so a frame of frame_width*frame_height
// pixels is followed by frame_width+1 flush transactions. Neighbors outside the frame
// count as zero. A transaction passes IDLE and READ; with a result also CALC and DONE,
// in Sobel mode with SQ, START and ROOT between, where ROOT waits for the eight-step square
// root. READ fills the window from registered reads of both line memories, which need no
// clearing after reset. A result waiting at the output holds the next transaction back
// once that one is finished. Writing the frame width or height restarts the frame.
`include "assert_macros.svh"
module conv3x3_blur_sobel_unit import c3bs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  c3bs_in_if.sink               in_ch,
  c3bs_out_if.source            out_ch,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  state_t state;

  logic                mode;
  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;

  logic [PIX_W-1:0] mem_one [MAX_WIDTH];
  logic [PIX_W-1:0] mem_two [MAX_WIDTH];
  logic [PIX_W-1:0] rd_one;
  logic [PIX_W-1:0] rd_two;
  logic [PIX_W-1:0] win [9];
  logic [PIX_W-1:0] fresh;
  logic [COL_W-1:0] col;

  logic [COL_W-1:0]   in_column;
  logic [INROW_W-1:0] in_row;
  logic [COL_W-1:0]   out_column;
  logic [ROW_W-1:0]   out_row;
  logic [WIDTH_W-1:0] fill_count;

  logic       produce;
  logic [8:0] mask;
  logic       last;

  logic signed [10:0] gx [3];
  logic signed [10:0] gy [3];
  logic [SQ_W-1:0]    sq [3];
  logic [7:0]         res [3];
  logic [7:0]         root [3];
  logic [2:0]         busy;
  logic               sqrt_start;

  logic accept;
  logic tail;
  logic match;
  logic col_wrap;
  logic last_now;
  logic filled;
  logic out_load;
  logic top_ok;
  logic bot_ok;
  logic left_ok;
  logic right_ok;
  logic [WIDTH_W-1:0]  w_sat;
  logic [HEIGHT_W-1:0] h_sat;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign tail        = (in_row >= INROW_W'(frame_height));
  assign match       = (in_ch.kind == (tail ? KIND_FLUSH : KIND_PIXEL));
  assign col_wrap    = (WIDTH_W'(in_column) + 1'b1 >= frame_width);
  assign top_ok      = (out_row != '0);
  assign bot_ok      = (HEIGHT_W'(out_row) + 1'b1 < frame_height);
  assign left_ok     = (out_column != '0);
  assign right_ok    = (WIDTH_W'(out_column) + 1'b1 < frame_width);
  assign last_now    = !bot_ok && !right_ok;
  assign filled      = (fill_count >= frame_width + 1'b1);
  assign out_load    = (state == S_DONE) && !cfg_write && (!out_ch.valid || out_ch.ready);
  assign sqrt_start  = (state == S_START);

  always_comb begin
    w_sat = WIDTH_W'(cfg_data[11:0]);
    if (cfg_data[11:0] == 12'd0) begin
      w_sat = WIDTH_W'(1);
    end else if ({1'b0, cfg_data[11:0]} > 13'(MAX_WIDTH)) begin
      w_sat = WIDTH_W'(MAX_WIDTH);
    end
    h_sat = HEIGHT_W'(cfg_data[12:0]);
    if (cfg_data[12:0] == 13'd0) begin
      h_sat = HEIGHT_W'(1);
    end else if ({1'b0, cfg_data[12:0]} > 14'(MAX_HEIGHT)) begin
      h_sat = HEIGHT_W'(MAX_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_one <= mem_one[in_column];
      rd_two <= mem_two[in_column];
    end
    if (state == S_READ) begin
      mem_one[col] <= fresh;
      mem_two[col] <= rd_one;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '{default: '0};
    end else if (state == S_READ) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= rd_two;
      win[5] <= rd_one;
      win[8] <= fresh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mode         <= MODE_BLUR;
      frame_width  <= WIDTH_W'(640);
      frame_height <= HEIGHT_W'(480);
      in_column    <= '0;
      in_row       <= '0;
      out_column   <= '0;
      out_row      <= '0;
      fill_count   <= '0;
      produce      <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MODE: mode <= cfg_data[0];
          REG_WIDTH, REG_HEIGHT: begin
            if (cfg_index == REG_WIDTH) begin
              frame_width <= w_sat;
            end else begin
              frame_height <= h_sat;
            end
            in_column  <= '0;
            in_row     <= '0;
            out_column <= '0;
            out_row    <= '0;
            fill_count <= '0;
          end
          default: ;
        endcase
      end else begin
        unique case (state)
          S_IDLE: begin
            if (accept && match) begin
              state <= S_READ;
              fresh <= tail ? '0 : {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
              col   <= in_column;
              mask  <= {bot_ok && right_ok, bot_ok, bot_ok && left_ok,
                        right_ok, 1'b1, left_ok,
                        top_ok && right_ok, top_ok, top_ok && left_ok};
              last  <= last_now;
              if (filled && last_now) begin
                in_column <= '0;
                in_row    <= '0;
              end else if (col_wrap) begin
                in_column <= '0;
                in_row    <= in_row + 1'b1;
              end else begin
                in_column <= in_column + 1'b1;
              end
              if (!filled) begin
                fill_count <= fill_count + 1'b1;
                produce    <= 1'b0;
              end else begin
                produce <= 1'b1;
                if (last_now) begin
                  out_column <= '0;
                  out_row    <= '0;
                  fill_count <= '0;
                end else if (!right_ok) begin
                  out_column <= '0;
                  out_row    <= out_row + 1'b1;
                end else begin
                  out_column <= out_column + 1'b1;
                end
              end
            end
          end
          S_READ:  state <= produce ? S_CALC : S_IDLE;
          S_CALC:  state <= (mode == MODE_BLUR) ? S_DONE : S_SQ;
          S_SQ:    state <= S_START;
          S_START: state <= S_ROOT;
          S_ROOT: begin
            if (busy == 3'b000) begin
              state <= S_DONE;
            end
          end
          S_DONE: begin
            if (out_load) begin
              state <= S_IDLE;
            end
          end
          default: state <= S_IDLE;
        endcase
      end
    end
  end

  // Per channel datapath: masked taps, blur sum or gradients, then squares and their square root.
  for (genvar c = 0; c < 3; c++) begin : g_chan
    logic [7:0]         p [9];
    logic [9:0]         blur;
    logic signed [10:0] gx_c;
    logic signed [10:0] gy_c;
    logic signed [21:0] sqx;
    logic signed [21:0] sqy;

    always_comb begin
      for (int i = 0; i < 9; i++) begin
        p[i] = mask[i] ? chan(win[i], 2'(c)) : 8'd0;
      end
      blur = 10'(p[0] >> 4) + 10'(p[1] >> 3) + 10'(p[2] >> 4)
           + 10'(p[3] >> 3) + 10'(p[4] >> 2) + 10'(p[5] >> 3)
           + 10'(p[6] >> 4) + 10'(p[7] >> 3) + 10'(p[8] >> 4);
      gx_c = $signed({3'b000, p[2]}) + $signed({2'b00, p[5], 1'b0}) + $signed({3'b000, p[8]})
           - $signed({3'b000, p[0]}) - $signed({2'b00, p[3], 1'b0}) - $signed({3'b000, p[6]});
      gy_c = $signed({3'b000, p[6]}) + $signed({2'b00, p[7], 1'b0}) + $signed({3'b000, p[8]})
           - $signed({3'b000, p[0]}) - $signed({2'b00, p[1], 1'b0}) - $signed({3'b000, p[2]});
      sqx = gx[c] * gx[c];
      sqy = gy[c] * gy[c];
    end

    always_ff @(posedge clk) begin
      if (state == S_CALC) begin
        gx[c]  <= gx_c;
        gy[c]  <= gy_c;
        res[c] <= blur[7:0];
      end
      if (state == S_SQ) begin
        sq[c] <= SQ_W'($unsigned(sqx) + $unsigned(sqy));
      end
    end

    c3bs_isqrt u_isqrt (
      .clk      (clk),
      .rst      (rst),
      .start    (sqrt_start),
      .value    (sq[c]),
      .root_out (root[c]),
      .busy     (busy[c])
    );
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.red_out       <= (mode == MODE_BLUR) ? res[0] : root[0];
      out_ch.green_out     <= (mode == MODE_BLUR) ? res[1] : root[1];
      out_ch.blue_out      <= (mode == MODE_BLUR) ? res[2] : root[2];
      out_ch.last_of_frame <= last;
    end
  end

  `ASSERT_ALWAYS(a_col_in_frame, clk, rst, WIDTH_W'(in_column) < frame_width, "input column past frame width")
  `ASSERT_ALWAYS(a_out_row_in_frame, clk, rst, HEIGHT_W'(out_row) < frame_height, "output row past frame height")
  `ASSERT_ALWAYS(a_fill_bound, clk, rst, fill_count <= frame_width + 1'b1, "fill count past its limit")
  `ASSERT_NEXT(a_sqrt_runs, clk, rst, state == S_START, busy == 3'b111, "square root units did not start")
endmodule
